[src/plb_pkg.sv]
// ----------------------------------------------------------------------------
// plb_pkg
// Shared constants and controller/datapath interface types for the page-mode
// bitmap blit.
// ----------------------------------------------------------------------------
package plb_pkg;

	localparam int HALF_COLUMNS = 64;
	localparam int PAGES        = 8;
	localparam int MAX_WIDTH    = 128;

	localparam int TOTAL_COLS   = 2 * HALF_COLUMNS;
	localparam int TOTAL_ROWS   = 8 * PAGES;
	localparam int MIRROR_DEPTH = 2 * PAGES * HALF_COLUMNS;

	localparam int COL_W   = $clog2(TOTAL_COLS);
	localparam int HCOL_W  = $clog2(HALF_COLUMNS);
	localparam int PAGE_W  = $clog2(PAGES);
	localparam int MIR_AW  = $clog2(MIRROR_DEPTH);
	localparam int PREV_AW = $clog2(MAX_WIDTH);

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;

	localparam logic KIND_BEGIN = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic clr_wr;
		logic rd_first;
		logic rd_second;
		logic push_begin;
		logic push_first;
		logic push_second;
	} plb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_kind;
		logic active;
		logic trail;
		logic out_free;
		logic clr_done;
	} plb_stat_t;

endpackage

[src/page_lcd_bitmap_blit.sv]
// ----------------------------------------------------------------------------
// page_lcd_bitmap_blit
// Blits vertical-byte bitmaps onto a two-half page-mode display, producing
// display byte writes merged against a frame mirror of the panel contents.
//
// Channel  Dir  Signals                       Payload
// s_*      in   tvalid tready tdata tuser     blit begin geometry or one bitmap byte
// m_*      out  tvalid tready tdata tuser tlast  display write or begin status
//
// After reset the frame mirror is cleared to zero; s_tready stays low until then.
// A begin request returns its status from S_BEGIN; a bitmap byte makes one
// display write or two, each a mirror read followed by a write through the single
// mirror port that serves the read and write of each read-modify-write.
// A stalled m_tready holds the result register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module page_lcd_bitmap_blit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pos_x[7:0], pos_y[15:8], width[23:16], height[30:24], wrap[31],
	// pixel_byte[39:32]
	input  logic [39:0] s_tdata,
	// kind[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// half[0], page[3:1], column[9:4], write_byte[17:10], status[18], zero fill
	output logic [23:0] m_tdata,
	// is_write[0]
	output logic        m_tuser,
	// last
	output logic        m_tlast
);
	import plb_pkg::*;

	plb_cmd_t  cmd;
	plb_stat_t stat;

	plb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	plb_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

[src/plb_ctrl.sv]
// ----------------------------------------------------------------------------
// plb_ctrl
// Sequencer for the blit: mirror clearing pass, request dispatch and the
// read-modify-write steps for one or two display writes per bitmap byte.
// ----------------------------------------------------------------------------
module plb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  plb_pkg::plb_stat_t stat,
	output plb_pkg::plb_cmd_t  cmd
);
	import plb_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_BEGIN = 3'd2;
	localparam logic [2:0] S_RD1   = 3'd3;
	localparam logic [2:0] S_WR1   = 3'd4;
	localparam logic [2:0] S_RD2   = 3'd5;
	localparam logic [2:0] S_WR2   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.latch = 1'b1;
					if (stat.in_kind == KIND_BEGIN) begin
						state_d = S_BEGIN;
					end else if (stat.active) begin
						state_d = S_RD1;
					end
				end
			end
			S_BEGIN: begin
				if (stat.out_free) begin
					cmd.push_begin = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_RD1: begin
				cmd.rd_first = 1'b1;
				state_d      = S_WR1;
			end
			S_WR1: begin
				if (stat.out_free) begin
					cmd.push_first = 1'b1;
					state_d        = stat.trail ? S_RD2 : S_IDLE;
				end
			end
			S_RD2: begin
				cmd.rd_second = 1'b1;
				state_d       = S_WR2;
			end
			S_WR2: begin
				if (stat.out_free) begin
					cmd.push_second = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/plb_dpath.sv]
// ----------------------------------------------------------------------------
// plb_dpath
// Request latch, blit geometry and position counters, frame mirror, previous
// row store, byte merge logic and the result register.
// ----------------------------------------------------------------------------
module plb_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [plb_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tuser,
	output logic [plb_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  plb_pkg::plb_cmd_t                 cmd,
	output plb_pkg::plb_stat_t                stat
);
	import plb_pkg::*;

	// Latched request fields.
	logic [7:0] x_in_q;
	logic [7:0] y_in_q;
	logic [7:0] w_in_q;
	logic [6:0] h_in_q;
	logic       wrap_in_q;
	logic [7:0] byte_q;

	// Geometry and position of the running blit.
	logic              active_q;
	logic [COL_W-1:0]  gx_q;
	logic [2:0]        shift_q;
	logic [PAGE_W-1:0] pg0_q;
	logic [7:0]        gw_q;
	logic [3:0]        rows_q;
	logic [3:0]        row_q;
	logic [PREV_AW-1:0] col_q;

	logic [MIR_AW-1:0] clr_cnt_q;

	logic [7:0] mirror_mem [MIRROR_DEPTH];
	logic [7:0] prev_mem [MAX_WIDTH];
	logic [7:0] mir_rd_q;
	logic [7:0] prev_rd_q;

	logic out_valid_q;
	logic out_user_q;
	logic out_last_q;
	logic out_half_q;
	logic [2:0] out_page_q;
	logic [5:0] out_col_q;
	logic [7:0] out_byte_q;
	logic out_status_q;

	logic              err;
	logic              start;
	logic [8:0]        x_end;
	logic [8:0]        y_end;
	logic [COL_W-1:0]  col_abs;
	logic              half;
	logic [HCOL_W-1:0] hcol;
	logic [PAGE_W-1:0] page1;
	logic [PAGE_W-1:0] page2;
	logic [MIR_AW-1:0] idx1;
	logic [MIR_AW-1:0] idx2;
	logic [MIR_AW-1:0] mir_addr;
	logic [7:0]        mir_wdata;
	logic              mir_we;
	logic              mir_rd;
	logic              trail;
	logic              finish;
	logic [3:0]        inv_shift;
	logic [7:0]        v1;
	logic [7:0]        v2;
	logic [7:0]        col_next;
	logic [4:0]        row_next;
	logic              out_free;

	// Begin checks.
	assign x_end = {1'b0, x_in_q} + {1'b0, w_in_q};
	assign y_end = {1'b0, y_in_q} + {2'b00, h_in_q};
	assign err   = (h_in_q[2:0] != 3'd0) || (w_in_q > 8'(MAX_WIDTH)) ||
		(!wrap_in_q && ((x_end > 9'(TOTAL_COLS)) || (y_end > 9'(TOTAL_ROWS))));
	assign start = !err && (w_in_q != 8'd0) && (h_in_q != 7'd0);

	// Display position of the current source byte.
	assign col_abs = gx_q + COL_W'(col_q);
	assign half    = col_abs[COL_W-1];
	assign hcol    = col_abs[HCOL_W-1:0];
	assign page1   = pg0_q + row_q[PAGE_W-1:0];
	assign page2   = pg0_q + rows_q[PAGE_W-1:0];
	assign idx1    = {half, page1, hcol};
	assign idx2    = {half, page2, hcol};

	assign row_next = {1'b0, row_q} + 5'd1;
	assign trail    = (shift_q != 3'd0) && (row_next == {1'b0, rows_q});
	assign finish   = (cmd.push_first && !trail) || cmd.push_second;

	// Byte merge. The top page keeps the mirror bits above the bitmap; later rows
	// pull their upper bits from the byte one source row above.
	assign inv_shift = 4'd8 - {1'b0, shift_q};
	always_comb begin
		if (shift_q == 3'd0) begin
			v1 = byte_q;
		end else if (row_q == 4'd0) begin
			v1 = (mir_rd_q & (8'hFF >> inv_shift)) | (byte_q << shift_q);
		end else begin
			v1 = (byte_q << shift_q) | (prev_rd_q >> inv_shift);
		end
	end
	assign v2 = (mir_rd_q & (8'hFF << shift_q)) | (byte_q >> inv_shift);

	assign mir_we    = cmd.clr_wr || cmd.push_first || cmd.push_second;
	assign mir_rd    = cmd.rd_first || cmd.rd_second;
	assign mir_addr  = cmd.clr_wr ? clr_cnt_q :
		((cmd.rd_second || cmd.push_second) ? idx2 : idx1);
	assign mir_wdata = cmd.clr_wr ? 8'h00 : (cmd.push_second ? v2 : v1);

	always_ff @(posedge clk) begin
		if (mir_we) begin
			mirror_mem[mir_addr] <= mir_wdata;
		end
		if (mir_rd) begin
			mir_rd_q <= mirror_mem[mir_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			prev_mem[col_q] <= byte_q;
		end
		if (cmd.rd_first) begin
			prev_rd_q <= prev_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + MIR_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			x_in_q    <= s_tdata[7:0];
			y_in_q    <= s_tdata[15:8];
			w_in_q    <= s_tdata[23:16];
			h_in_q    <= s_tdata[30:24];
			wrap_in_q <= s_tdata[31];
			byte_q    <= s_tdata[39:32];
		end
	end

	assign col_next = {1'b0, col_q} + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			gx_q     <= '0;
			shift_q  <= '0;
			pg0_q    <= '0;
			gw_q     <= '0;
			rows_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
		end else if (cmd.push_begin) begin
			active_q <= start;
			if (start) begin
				gx_q    <= x_in_q[COL_W-1:0];
				shift_q <= y_in_q[2:0];
				pg0_q   <= y_in_q[PAGE_W+2:3];
				gw_q    <= w_in_q;
				rows_q  <= h_in_q[6:3];
				row_q   <= '0;
				col_q   <= '0;
			end
		end else if (finish) begin
			if (col_next >= gw_q) begin
				col_q <= '0;
				if (row_next >= {1'b0, rows_q}) begin
					row_q    <= '0;
					active_q <= 1'b0;
				end else begin
					row_q <= row_next[3:0];
				end
			end else begin
				col_q <= col_next[PREV_AW-1:0];
			end
		end
	end

	// Result register.
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_begin || cmd.push_first || cmd.push_second) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_begin) begin
			out_user_q   <= 1'b0;
			out_half_q   <= 1'b0;
			out_page_q   <= '0;
			out_col_q    <= '0;
			out_byte_q   <= '0;
			out_status_q <= err;
			out_last_q   <= 1'b1;
		end else if (cmd.push_first || cmd.push_second) begin
			out_user_q   <= 1'b1;
			out_half_q   <= half;
			out_page_q   <= cmd.push_second ? page2 : page1;
			out_col_q    <= hcol;
			out_byte_q   <= cmd.push_second ? v2 : v1;
			out_status_q <= 1'b0;
			out_last_q   <= cmd.push_second || !trail;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'b00000, out_status_q, out_byte_q, out_col_q, out_page_q, out_half_q};

	assign stat.in_kind  = s_tuser;
	assign stat.active   = active_q;
	assign stat.trail    = trail;
	assign stat.out_free = out_free;
	assign stat.clr_done = &clr_cnt_q;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_begin || cmd.push_first || cmd.push_second) |-> out_free)
		else $error("result pushed while the result register is still held");

	a_push_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push_begin, cmd.push_first, cmd.push_second, cmd.clr_wr}))
		else $error("more than one mirror or result command in one cycle");

	a_second_trail: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_second |-> trail && active_q && (shift_q != 3'd0))
		else $error("trailing page write outside the final unaligned row");

	a_first_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_first && trail |=> !out_last_q && out_valid_q)
		else $error("first write of a two-write byte marked as last");

endmodule
